// ===== sv/mrot_pkg.sv =====
// Package: types, codes and binary32 datapath functions for the rotation core.
package mrot_pkg;

  typedef enum logic [1:0] {
    MODE_IDENT = 2'd0,
    MODE_FULL  = 2'd1,
    MODE_UDIAG = 2'd2,
    MODE_UOFF  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_H11  = 3'd1,
    REG_H21  = 3'd2,
    REG_H12  = 3'd3,
    REG_H22  = 3'd4
  } reg_idx_e;

  // significand width of the internal format: value = sig / 2^(SW-1) * 2^(exp-127)
  localparam int SW = 50;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  typedef logic signed [10:0] exp_t;

  typedef struct packed {
    logic           spec;      // result already known, in spec_val
    logic [31:0]    spec_val;
    logic           sign;
    exp_t           exp;
    logic [SW-1:0]  sig;
  } norm_t;

  typedef struct packed {
    logic           spec;
    logic [31:0]    spec_val;
    logic           sign;
    logic           sub;
    exp_t           exp;
    logic [SW-1:0]  a;         // larger magnitude
    logic [SW-1:0]  b;         // aligned smaller magnitude, sticky in lsb
  } align_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } pass_t;

  function automatic logic is_nan(input logic [31:0] f);
    return (&f[30:23]) && (|f[22:0]);
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return (&f[30:23]) && !(|f[22:0]);
  endfunction

  function automatic logic is_zero(input logic [31:0] f);
    return f[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] mant(input logic [31:0] f);
    return {|f[30:23], f[22:0]};
  endfunction

  // subnormals use exponent 1 with a clear hidden bit
  function automatic exp_t eexp(input logic [31:0] f);
    return (f[30:23] == 8'd0) ? exp_t'(1) : exp_t'({3'b000, f[30:23]});
  endfunction

  function automatic norm_t fmul_unpack(input logic [31:0] a, input logic [31:0] b);
    norm_t       r;
    logic [47:0] p;
    r          = '0;
    r.sign     = a[31] ^ b[31];
    p          = 48'(mant(a)) * 48'(mant(b));
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) begin
      r.spec     = 1'b1;
      r.spec_val = QNAN;
    end else if (is_inf(a) || is_inf(b)) begin
      r.spec     = 1'b1;
      r.spec_val = {r.sign, 8'hFF, 23'd0};
    end else if (is_zero(a) || is_zero(b)) begin
      r.spec     = 1'b1;
      r.spec_val = {r.sign, 31'd0};
    end else begin
      r.sig = {p, 2'b00};
      r.exp = eexp(a) + eexp(b) - exp_t'(126);
    end
    return r;
  endfunction

  // left-justify the significand
  function automatic norm_t fnorm(input norm_t n);
    norm_t r;
    int    lz;
    r  = n;
    lz = 0;
    for (int i = 0; i < SW; i++) begin
      if (n.sig[i]) lz = SW - 1 - i;
    end
    if (!n.spec) begin
      r.sig = n.sig << lz;
      r.exp = n.exp - exp_t'(lz);
    end
    return r;
  endfunction

  // round to nearest even and pack, subnormal and overflow included
  function automatic logic [31:0] fround(input norm_t n);
    logic [5:0]    sh;
    logic [SW-1:0] m;
    logic          lost;
    logic          g;
    logic          st;
    logic          inc;
    logic [7:0]    ef;
    logic [23:0]   keep;
    logic [30:0]   body;
    if (n.exp >= exp_t'(1)) begin
      sh = 6'd0;
      ef = n.exp[7:0];
    end else begin
      ef = 8'd0;
      sh = (n.exp < exp_t'(-61)) ? 6'd63 : 6'(exp_t'(1) - n.exp);
    end
    m    = n.sig >> sh;
    lost = |(n.sig & ~({SW{1'b1}} << sh));
    keep = m[SW-1:SW-24];
    g    = m[SW-25];
    st   = (|m[SW-26:0]) | lost;
    inc  = g & (st | keep[0]);
    body = {ef, keep[22:0]} + 31'(inc);
    if (n.spec) return n.spec_val;
    if (n.exp >= exp_t'(255)) return {n.sign, 8'hFF, 23'd0};
    return {n.sign, body};
  endfunction

  function automatic align_t fadd_align(input logic [31:0] a, input logic [31:0] b);
    align_t        r;
    logic [31:0]   big;
    logic [31:0]   sml;
    logic [SW-1:0] bs;
    exp_t          d;
    r   = '0;
    big = (b[30:0] > a[30:0]) ? b : a;
    sml = (b[30:0] > a[30:0]) ? a : b;
    d   = eexp(big) - eexp(sml);
    bs  = {1'b0, mant(sml), 25'd0};
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
      r.spec     = 1'b1;
      r.spec_val = QNAN;
    end else if (is_inf(a)) begin
      r.spec     = 1'b1;
      r.spec_val = a;
    end else if (is_inf(b)) begin
      r.spec     = 1'b1;
      r.spec_val = b;
    end else if (is_zero(a) && is_zero(b)) begin
      r.spec     = 1'b1;
      r.spec_val = {a[31] & b[31], 31'd0};
    end else if (is_zero(a)) begin
      r.spec     = 1'b1;
      r.spec_val = b;
    end else if (is_zero(b)) begin
      r.spec     = 1'b1;
      r.spec_val = a;
    end else begin
      r.sign = big[31];
      r.sub  = a[31] ^ b[31];
      r.exp  = eexp(big) + exp_t'(1);
      r.a    = {1'b0, mant(big), 25'd0};
      if (d >= exp_t'(SW)) begin
        r.b = SW'(1);
      end else begin
        r.b = (bs >> d) | SW'(|(bs & ~({SW{1'b1}} << d)));
      end
    end
    return r;
  endfunction

  function automatic norm_t fadd_sum(input align_t al);
    norm_t         r;
    logic [SW-1:0] s;
    s          = al.sub ? (al.a - al.b) : (al.a + al.b);
    r.spec     = al.spec;
    r.spec_val = al.spec_val;
    r.sign     = al.sign;
    r.exp      = al.exp;
    r.sig      = s;
    if (!al.spec && (s == '0)) begin
      r.spec     = 1'b1;
      r.spec_val = 32'd0;   // exact cancellation gives +0
    end
    return r;
  endfunction

endpackage

// ===== sv/modified_givens_rotation_apply_core.sv =====
// Top level: modified Givens rotation applied to a stream of binary32 pairs.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) moves one word: x_value_i, y_value_i
//   and last_in_i. Output channel (out_valid_o/out_ready_i) returns one word
//   per input: x_result_o, y_result_o and last_out_o (last_in copied).
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 mode, 1 h11, 2 h21, 3 h12, 4 h22); other indexes are dropped. Write it
//   only while the pipe is empty.
// Pipeline: seven register stages; out_valid_o is the valid bit of the last one.
//   Stages: operand unpack + 24x24 mantissa multiply, product normalize,
//   product round, add operand select + align, add/sub, normalize, round.
// Throughput: one word per cycle while the output word is not held; the four
//   multipliers and two adders are fully pipelined.
// Stall: when the output word is held, the whole pipe freezes and in_ready_o
//   drops; nothing is lost or repeated. in_ready_o is high whenever the
//   output register is empty or being taken.
// Reset: clears all valid bits and the config registers (identity mode,
//   zero coefficients).
// Mode identity returns input bits untouched; other modes return NaN
//   results as the canonical quiet NaN.
module modified_givens_rotation_apply_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] x_value_i,
  input  logic [31:0] y_value_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] x_result_o,
  output logic [31:0] y_result_o,
  output logic        last_out_o
);

  // ---------------- configuration ----------------
  mrot_pkg::mode_e mode_q;
  logic [31:0]     h11_q, h21_q, h12_q, h22_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mrot_pkg::MODE_IDENT;
      h11_q  <= '0;
      h21_q  <= '0;
      h12_q  <= '0;
      h22_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mrot_pkg::REG_MODE: mode_q <= mrot_pkg::mode_e'(cfg_data_i[1:0]);
        mrot_pkg::REG_H11:  h11_q  <= cfg_data_i;
        mrot_pkg::REG_H21:  h21_q  <= cfg_data_i;
        mrot_pkg::REG_H12:  h12_q  <= cfg_data_i;
        mrot_pkg::REG_H22:  h22_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Single enable: every stage moves together, the last stage is the output register.
  logic [6:0] v_q;
  logic       stage_en;

  assign stage_en   = !v_q[6] || out_ready_i;
  assign in_ready_o = stage_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (stage_en) begin
      v_q <= {v_q[5:0], in_valid_i};
    end
  end

  // ---------------- datapath ----------------
  // product lanes: 0 x*h11, 1 y*h12, 2 x*h21, 3 y*h22
  mrot_pkg::pass_t  pass_q [6];
  mrot_pkg::norm_t  m1_q   [4];
  mrot_pkg::norm_t  m2_q   [4];
  logic [31:0]      p_q    [4];
  mrot_pkg::align_t al_q   [2];
  mrot_pkg::norm_t  s5_q   [2];
  mrot_pkg::norm_t  s6_q   [2];
  logic [31:0]      x_res_q, y_res_q;
  logic             last_q;

  // adder operands: a product or the raw/negated element, by mode
  logic [31:0] add_a_d [2];
  logic [31:0] add_b_d [2];

  always_comb begin
    add_a_d[0] = (mode_q == mrot_pkg::MODE_UDIAG) ? pass_q[2].x : p_q[0];
    add_b_d[0] = (mode_q == mrot_pkg::MODE_UOFF)  ? pass_q[2].y : p_q[1];
    add_a_d[1] = (mode_q == mrot_pkg::MODE_UOFF)  ? {~pass_q[2].x[31], pass_q[2].x[30:0]}
                                                 : p_q[2];
    add_b_d[1] = (mode_q == mrot_pkg::MODE_UDIAG) ? pass_q[2].y : p_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (stage_en) begin
      pass_q[0] <= '{x: x_value_i, y: y_value_i, last: last_in_i};
      for (int k = 1; k < 6; k++) pass_q[k] <= pass_q[k-1];
      m1_q[0] <= mrot_pkg::fmul_unpack(x_value_i, h11_q);
      m1_q[1] <= mrot_pkg::fmul_unpack(y_value_i, h12_q);
      m1_q[2] <= mrot_pkg::fmul_unpack(x_value_i, h21_q);
      m1_q[3] <= mrot_pkg::fmul_unpack(y_value_i, h22_q);
      for (int l = 0; l < 4; l++) begin
        m2_q[l] <= mrot_pkg::fnorm(m1_q[l]);
        p_q[l]  <= mrot_pkg::fround(m2_q[l]);
      end
      for (int j = 0; j < 2; j++) begin
        al_q[j] <= mrot_pkg::fadd_align(add_a_d[j], add_b_d[j]);
        s5_q[j] <= mrot_pkg::fadd_sum(al_q[j]);
        s6_q[j] <= mrot_pkg::fnorm(s5_q[j]);
      end
      x_res_q <= (mode_q == mrot_pkg::MODE_IDENT) ? pass_q[5].x : mrot_pkg::fround(s6_q[0]);
      y_res_q <= (mode_q == mrot_pkg::MODE_IDENT) ? pass_q[5].y : mrot_pkg::fround(s6_q[1]);
      last_q  <= pass_q[5].last;
    end
  end

  assign out_valid_o = v_q[6];
  assign x_result_o  = x_res_q;
  assign y_result_o  = y_res_q;
  assign last_out_o  = last_q;

  // ---------------- assertions ----------------
  a_x_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_q != mrot_pkg::MODE_IDENT) && (&x_result_o[30:23])
     && (|x_result_o[22:0])) |-> (x_result_o == mrot_pkg::QNAN))
    else $error("x result NaN not canonical");

  a_y_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_q != mrot_pkg::MODE_IDENT) && (&y_result_o[30:23])
     && (|y_result_o[22:0])) |-> (y_result_o == mrot_pkg::QNAN))
    else $error("y result NaN not canonical");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_en |=> $stable(v_q))
    else $error("pipe valid bits moved during stall");

endmodule
